>>> src/krc_pkg.sv
// ----------------------------------------------------------------------------
// krc_pkg - shared types and constants of the keyed ring cache
// Sizes, command/response structs, codes and ring index helpers.
// ----------------------------------------------------------------------------
package krc_pkg;

    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;
    localparam int KEY_W      = 64;
    localparam int VAL_W      = 32;
    localparam int CAP_W      = 7;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int SUM_W      = IDX_W + 1;
    localparam int RAM_W      = KEY_W + DATA_WIDTH;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

    typedef enum logic [1:0] {
        KIND_GET = 2'd0,
        KIND_ADD = 2'd1,
        KIND_DEL = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY,
        ST_SHIFT
    } t_state;

    typedef struct packed {
        logic [1:0]       kind;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] data_out;
        logic             evicted;
    } t_rsp;

    // Ring slot of a logical position; the sum stays below twice the depth.
    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] oldest,
                                                 input logic [CNT_W-1:0] logical);
        logic [SUM_W-1:0] s;
        s = {1'b0, oldest} + SUM_W'(logical);
        if (s >= SUM_W'(DEPTH)) begin
            s = s - SUM_W'(DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

    // Capacity clamped to 1..DEPTH.
    function automatic logic [CNT_W-1:0] eff_cap(input logic [CAP_W-1:0] c);
        logic [31:0] cw;
        cw = 32'(c);
        if (cw == 32'd0) begin
            return CNT_W'(1);
        end else if (cw > 32'(DEPTH)) begin
            return CNT_W'(DEPTH);
        end else begin
            return CNT_W'(c);
        end
    endfunction

endpackage

>>> src/krc_ram.sv
// ----------------------------------------------------------------------------
// krc_ram - simple dual-port synchronous RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module krc_ram #(
    parameter int DEPTH_P = 64,
    parameter int WIDTH_P = 96,
    parameter int ADDR_W  = $clog2(DEPTH_P)
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [ADDR_W-1:0]  i_waddr,
    input  logic [WIDTH_P-1:0] i_wdata,
    input  logic               i_re,
    input  logic [ADDR_W-1:0]  i_raddr,
    output logic [WIDTH_P-1:0] o_rdata
);

    logic [WIDTH_P-1:0] r_mem [DEPTH_P];
    logic [WIDTH_P-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/keyed_ring_cache_fifo_evict.sv
// ----------------------------------------------------------------------------
// keyed_ring_cache_fifo_evict - fully associative key/data store, FIFO eviction
// Sequence: a get, add or delete scans the entries from the oldest and stops at
//   the first key match or after the last entry, then applies the result; a
//   delete hit with later entries then shifts them down by one. Other kinds
//   go straight to apply and return an empty result. One item at a time: no
//   new command is taken while busy, and results cannot be stalled.
// Reset: synchronous, active low; empties the store, capacity returns to 64.
// ----------------------------------------------------------------------------
module keyed_ring_cache_fifo_evict
    import krc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // command channel
    input  logic             start,
    output logic             busy,
    input  t_cmd             i_cmd,
    // result strobe
    output logic             o_rsp_valid,
    output t_rsp             o_rsp,
    // capacity register write
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CAP_W-1:0] i_cfg_data
);

    // Control state
    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;     // valid entries
    logic [IDX_W-1:0]    r_oldest, n_oldest;   // ring slot of logical entry 0
    logic [CAP_W-1:0]    r_cap, n_cap;
    logic                r_rvld, n_rvld;       // read data returning this cycle
    logic                r_rsp_valid, n_rsp_valid;

    // Payload / per-item working registers
    t_cmd                r_cmd, n_cmd;
    logic [CNT_W-1:0]    r_iss, n_iss;         // next logical index to read
    logic [IDX_W-1:0]    r_ridx, n_ridx;       // scan: index read; shift: destination
    logic                r_found, n_found;
    logic [IDX_W-1:0]    r_pos, n_pos;
    logic [DATA_WIDTH-1:0] r_hit_data, n_hit_data;
    t_rsp                r_rsp, n_rsp;

    // Ring memory: {key, data}
    logic                ram_we, ram_re;
    logic [IDX_W-1:0]    ram_waddr, ram_raddr;
    logic [RAM_W-1:0]    ram_wdata, ram_rdata;

    logic                cfg_xfer;
    logic                match_now;
    logic                iss_more;
    logic [CNT_W-1:0]    pos_next;

    krc_ram #(
        .DEPTH_P (DEPTH),
        .WIDTH_P (RAM_W),
        .ADDR_W  (IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign cfg_xfer    = i_cfg_valid && o_cfg_ready;
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    // Compare the entry that has just come back from the memory
    assign match_now = r_rvld && (ram_rdata[RAM_W-1:DATA_WIDTH] == r_cmd.key);
    assign iss_more  = (r_iss < r_count);
    assign pos_next  = CNT_W'(r_pos) + CNT_W'(1);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    if (i_cmd.kind == KIND_GET || i_cmd.kind == KIND_ADD ||
                        i_cmd.kind == KIND_DEL) begin
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_APPLY;
                    end
                end
            end
            ST_SCAN: begin
                // stop at the first match, or once every entry has been compared
                if (match_now || (!iss_more && !r_rvld)) begin
                    n_state = ST_APPLY;
                end
            end
            ST_APPLY: begin
                if (r_cmd.kind == KIND_DEL && r_found && pos_next < r_count) begin
                    n_state = ST_SHIFT;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_SHIFT: begin
                if (!iss_more && !r_rvld) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Datapath, memory controls and result
    always_comb begin
        n_count     = r_count;
        n_oldest    = r_oldest;
        n_cap       = r_cap;
        n_rvld      = 1'b0;
        n_rsp_valid = 1'b0;
        n_cmd       = r_cmd;
        n_iss       = r_iss;
        n_ridx      = r_ridx;
        n_found     = r_found;
        n_pos       = r_pos;
        n_hit_data  = r_hit_data;
        n_rsp       = r_rsp;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_waddr   = '0;
        ram_raddr   = '0;
        ram_wdata   = '0;

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_cmd   = i_cmd;
                    n_iss   = '0;
                    n_found = 1'b0;
                end
            end
            ST_SCAN: begin
                // one read issued per cycle; compared in the next cycle
                ram_re    = iss_more && !match_now;
                ram_raddr = slot_of(r_oldest, r_iss);
                n_rvld    = ram_re;
                n_ridx    = r_iss[IDX_W-1:0];
                if (ram_re) begin
                    n_iss = r_iss + CNT_W'(1);
                end
                if (match_now) begin
                    n_found    = 1'b1;
                    n_pos      = r_ridx;
                    n_hit_data = ram_rdata[DATA_WIDTH-1:0];
                end
            end
            ST_APPLY: begin
                n_rsp = '0;
                case (r_cmd.kind)
                    KIND_GET: begin
                        n_rsp.hit = r_found;
                        if (r_found) begin
                            n_rsp.data_out = VAL_W'(r_hit_data);
                        end
                        n_rsp_valid = 1'b1;
                    end
                    KIND_ADD: begin
                        ram_we    = 1'b1;
                        ram_wdata = {r_cmd.key, DATA_WIDTH'(r_cmd.value)};
                        if (r_found) begin
                            // update in place
                            ram_waddr = slot_of(r_oldest, CNT_W'(r_pos));
                            n_rsp.hit = 1'b1;
                        end else begin
                            // append after the newest; when full, drop the oldest
                            ram_waddr = slot_of(r_oldest, r_count);
                            if (r_count >= eff_cap(r_cap)) begin
                                n_oldest      = slot_of(r_oldest, CNT_W'(1));
                                n_rsp.evicted = 1'b1;
                            end else begin
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        n_rsp_valid = 1'b1;
                    end
                    KIND_DEL: begin
                        if (r_found && pos_next < r_count) begin
                            // close the gap: move entries pos+1.. down by one
                            n_iss = pos_next;
                        end else begin
                            if (r_found) begin
                                n_count   = r_count - CNT_W'(1);
                                n_rsp.hit = 1'b1;
                            end
                            n_rsp_valid = 1'b1;
                        end
                    end
                    default: begin
                        n_rsp_valid = 1'b1;
                    end
                endcase
            end
            ST_SHIFT: begin
                // read entry i while the entry read before it is written one position down
                ram_re    = iss_more;
                ram_raddr = slot_of(r_oldest, r_iss);
                n_rvld    = ram_re;
                n_ridx    = IDX_W'(r_iss - CNT_W'(1));
                if (ram_re) begin
                    n_iss = r_iss + CNT_W'(1);
                end
                if (r_rvld) begin
                    ram_we    = 1'b1;
                    ram_waddr = slot_of(r_oldest, CNT_W'(r_ridx));
                    ram_wdata = ram_rdata;
                end
                if (!iss_more && !r_rvld) begin
                    n_count     = r_count - CNT_W'(1);
                    n_rsp       = '0;
                    n_rsp.hit   = 1'b1;
                    n_rsp_valid = 1'b1;
                end
            end
            default: begin
            end
        endcase

        // capacity transfer empties the store
        if (cfg_xfer) begin
            n_cap    = i_cfg_data;
            n_count  = '0;
            n_oldest = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_oldest    <= '0;
            r_cap       <= CAP_RESET;
            r_rvld      <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_oldest    <= n_oldest;
            r_cap       <= n_cap;
            r_rvld      <= n_rvld;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_iss      <= n_iss;
        r_ridx     <= n_ridx;
        r_found    <= n_found;
        r_pos      <= n_pos;
        r_hit_data <= n_hit_data;
        r_rsp      <= n_rsp;
    end

endmodule

>>> src/krc_checker.sv
// ----------------------------------------------------------------------------
// krc_checker - port-level assertions for the keyed ring cache
// Checks command/result sequencing and result field consistency.
// ----------------------------------------------------------------------------
module krc_checker
    import krc_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_rsp_valid,
    input t_rsp o_rsp
);

    // a result only closes an item that was in progress
    a_rsp_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> $past(busy))
        else $error("result strobe without an item in progress");

    // result strobes never abut
    a_rsp_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |=> !o_rsp_valid)
        else $error("back-to-back result strobes");

    // an accepted command always occupies the block
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("command transfer did not raise busy");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && !o_rsp.hit) |-> (o_rsp.data_out == '0))
        else $error("data returned on a miss");

    // eviction only happens on an add that missed
    a_evict_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp.evicted) |-> !o_rsp.hit)
        else $error("eviction flagged with a hit");

endmodule

bind keyed_ring_cache_fifo_evict krc_checker u_krc_checker (.*);
